[design/mbf_pkg.sv]
// mbf_pkg: beat types, mode and status codes for the mbf/ieee float converter
// no dependencies
package mbf_pkg;

  typedef enum logic [1:0] {
    MODE_DEC32 = 2'd0,
    MODE_ENC32 = 2'd1,
    MODE_DEC64 = 2'd2,
    MODE_ENC64 = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] data_in;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] data_out;
    logic [1:0]  status;
  } out_beat_t;

endpackage

[design/mbf_ieee_float_converter.sv]
// mbf_ieee_float_converter: mbf <-> ieee 754 single/double conversion
// depends on mbf_pkg
// pipeline: input register, then result register
// throughput: one beat per cycle while out_stall_i is low, set by the single combinational pass between them
// reset: asynchronous active low, clears both stage valid flags; payload is not reset
module mbf_ieee_float_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mbf_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mbf_pkg::out_beat_t out_beat_o
);
  import mbf_pkg::*;

  logic      a_valid_q;
  in_beat_t  a_q;
  logic      b_valid_q;
  out_beat_t b_q;
  out_beat_t res;
  logic      b_ready;
  logic      a_ready;

  assign b_ready     = !b_valid_q || !out_stall_i;
  assign a_ready     = !a_valid_q || b_ready;
  assign in_stall_o  = !a_ready;
  assign out_valid_o = b_valid_q;
  assign out_beat_o  = b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) a_q <= in_beat_i;
    if (b_ready && a_valid_q) b_q <= res;
  end

  // conversion
  logic [31:0] w32;
  logic [63:0] w64;
  logic [7:0]  d32_ex;
  logic [23:0] d32_sig;
  logic [23:0] d32_sh;
  logic [1:0]  d32_lost;
  logic        d32_up;
  logic [23:0] d32_rnd;
  logic [7:0]  e32_ex;
  logic [22:0] e32_frac;
  logic [7:0]  d64_ex;
  logic [52:0] d64_sig;
  logic [2:0]  d64_lost;
  logic        d64_up;
  logic [53:0] d64_rnd;
  logic [10:0] d64_iex;
  logic [10:0] e64_iex;

  always_comb begin
    w32 = a_q.data_in[31:0];
    w64 = a_q.data_in;
    res = '{data_out: 64'd0, status: ST_OK};

    d32_ex   = w32[31:24];
    d32_sig  = {1'b1, w32[22:0]};
    d32_sh   = (d32_ex == 8'd1) ? (d32_sig >> 2) : (d32_sig >> 1);
    d32_lost = (d32_ex == 8'd1) ? d32_sig[1:0] : {d32_sig[0], 1'b0};
    d32_up   = d32_lost[1] && (d32_lost[0] || d32_sh[0]);
    d32_rnd  = d32_sh + {23'd0, d32_up};

    e32_ex   = w32[30:23];
    e32_frac = w32[22:0];

    d64_ex   = w64[63:56];
    d64_sig  = {1'b1, w64[54:3]};
    d64_lost = w64[2:0];
    d64_up   = d64_lost[2] && (d64_lost[1] || d64_lost[0] || d64_sig[0]);
    d64_rnd  = {1'b0, d64_sig} + {53'd0, d64_up};
    d64_iex  = {3'd0, d64_ex} + 11'd894;

    e64_iex  = w64[62:52];

    unique case (mode_e'(a_q.mode))
      MODE_DEC32: begin
        if (d32_ex == 8'd0) begin
          res.data_out = 64'd0;
        end else if (d32_ex >= 8'd3) begin
          res.data_out = {32'd0, w32[23], d32_ex - 8'd2, w32[22:0]};
        end else begin
          res.data_out = {32'd0, w32[23], 7'd0, d32_rnd};
        end
      end
      MODE_ENC32: begin
        if (w32[30:0] == 31'd0) begin
          res.data_out = 64'd0;
        end else if (e32_ex == 8'hff) begin
          res.status = ST_OVER;
        end else if (e32_ex == 8'd0) begin
          if (!e32_frac[22] && !e32_frac[21]) begin
            res.status = ST_UNDER;
          end else if (e32_frac[22]) begin
            res.data_out = {32'd0, 8'd2, w32[31], e32_frac[21:0], 1'b0};
          end else begin
            res.data_out = {32'd0, 8'd1, w32[31], e32_frac[20:0], 2'b00};
          end
        end else if (e32_ex > 8'd253) begin
          res.status = ST_OVER;
        end else begin
          res.data_out = {32'd0, e32_ex + 8'd2, w32[31], e32_frac};
        end
      end
      MODE_DEC64: begin
        if (d64_ex == 8'd0) begin
          res.data_out = 64'd0;
        end else if (d64_rnd[53]) begin
          res.data_out = {w64[55], d64_iex + 11'd1, d64_rnd[52:1]};
        end else begin
          res.data_out = {w64[55], d64_iex, d64_rnd[51:0]};
        end
      end
      MODE_ENC64: begin
        if (w64[62:0] == 63'd0) begin
          res.data_out = 64'd0;
        end else if (e64_iex == 11'h7ff) begin
          res.status = ST_OVER;
        end else if (e64_iex < 11'd895) begin
          res.status = ST_UNDER;
        end else if (e64_iex > 11'd1149) begin
          res.status = ST_OVER;
        end else begin
          res.data_out = {e64_iex[7:0] + 8'd130, w64[63], w64[51:0], 3'd0};
        end
      end
      default: res = '{data_out: 64'd0, status: ST_OK};
    endcase
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && out_stall_i) |=> (b_valid_q && $stable(b_q)))
    else $error("result lost under stall");

  a_no_rsvd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (b_q.status != ST_RSVD))
    else $error("reserved status code");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_q.status != ST_OK) |-> (b_q.data_out == 64'd0))
    else $error("nonzero data with error status");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && b_ready) |=> b_valid_q)
    else $error("beat dropped between stages");

endmodule

[test/tb_mbf_ieee_float_converter.sv]
// tb_mbf_ieee_float_converter: random and directed test of the mbf/ieee float converter
// a scoreboard class predicts each result from the accepted input beat and checks outputs in order
// depends on mbf_pkg and mbf_ieee_float_converter
module tb_mbf_ieee_float_converter;
  timeunit 1ns;
  timeprecision 1ps;
  import mbf_pkg::*;

  class conv_scoreboard;
    out_beat_t pending_q[$];
    int unsigned n_errors;

    function new();
      n_errors = 0;
    endfunction

    function out_beat_t convert(in_beat_t b);
      out_beat_t r;
      logic [31:0] w, frac, sig, lost, half, top;
      logic [7:0] ex;
      logic [63:0] d, s64;
      logic [10:0] iex;
      int e, sh;
      r.data_out = '0;
      r.status = ST_OK;
      w = b.data_in[31:0];
      d = b.data_in;
      case (mode_e'(b.mode))
        MODE_DEC32: begin
          ex = w[31:24];
          frac = {9'd0, w[22:0]};
          if (ex >= 3) begin
            r.data_out = {32'd0, w[23], ex - 8'd2, w[22:0]};
          end else if (ex != 0) begin
            sig = 32'h800000 | frac;
            sh = 3 - ex;
            lost = sig & ((32'd1 << sh) - 1);
            half = 32'd1 << (sh - 1);
            sig = sig >> sh;
            if (lost > half || (lost == half && sig[0])) sig = sig + 32'd1;
            r.data_out = {32'd0, w[23], 31'd0} | {32'd0, sig};
          end
        end
        MODE_ENC32: begin
          ex = w[30:23];
          frac = {9'd0, w[22:0]};
          if (w[30:0] == 0) begin
          end else if (ex == 8'hff || ex > 253) begin
            r.status = ST_OVER;
          end else if (ex == 0 && frac < 32'h200000) begin
            r.status = ST_UNDER;
          end else begin
            if (ex == 0) begin
              top = frac[22] ? 32'd22 : 32'd21;
              frac = (frac << (32'd23 - top)) & 32'h7fffff;
              ex = 8'(top - 32'd20);
            end else begin
              ex = ex + 8'd2;
            end
            r.data_out = {32'd0, ex, w[31], frac[22:0]};
          end
        end
        MODE_DEC64: begin
          ex = d[63:56];
          if (ex != 0) begin
            s64 = {8'd1, d[54:0]};
            lost = {29'd0, s64[2:0]};
            s64 = s64 >> 3;
            if (lost > 4 || (lost == 4 && s64[0])) s64 = s64 + 64'd1;
            iex = 11'(ex) - 11'd129 + 11'd1023;
            if (s64 == 64'h20000000000000) begin
              s64 = s64 >> 1;
              iex = iex + 11'd1;
            end
            r.data_out = {d[55], iex, s64[51:0]};
          end
        end
        default: begin
          iex = d[62:52];
          e = int'(iex) - 1023;
          if (iex == 0 && d[51:0] == 0) begin
          end else if (iex == 11'h7ff || (iex != 0 && e > 126)) begin
            r.status = ST_OVER;
          end else if (iex == 0 || e < -128) begin
            r.status = ST_UNDER;
          end else begin
            r.data_out = {8'(e + 129), d[63], d[51:0], 3'd0};
          end
        end
      endcase
      return r;
    endfunction

    function void note_input(in_beat_t b);
      pending_q.push_back(convert(b));
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending_q.size() == 0) begin
        n_errors++;
        $display("%0t unexpected beat %h", $time, got);
        return;
      end
      want = pending_q.pop_front();
      if (got.data_out !== want.data_out) begin
        n_errors++;
        $display("%0t data_out exp %h got %h", $time, want.data_out, got.data_out);
      end
      if (got.status !== want.status) begin
        n_errors++;
        $display("%0t status exp %0d got %0d", $time, want.status, got.status);
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  in_beat_t in_beat;
  out_beat_t out_beat;
  conv_scoreboard sb;
  bit sending_done;

  mbf_ieee_float_converter i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_beat_i(in_beat),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_beat_o(out_beat)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_beat);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_beat);
  end

  task automatic send_beat(mode_e m, logic [63:0] d);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= '{mode: m, data_in: d};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] shaped_data();
    logic [63:0] d;
    d = rand64();
    case ($urandom_range(0, 5))
      0: d[31:24] = 8'($urandom_range(0, 3));
      1: d[30:23] = $urandom_range(0, 1) ? 8'hff : 8'($urandom_range(250, 255));
      2: d[30:23] = 8'd0;
      3: d[62:52] = 11'(1023 + $urandom_range(0, 260) - 131);
      4: d[63:56] = 8'($urandom_range(0, 2));
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) d[2:0] = 3'b100;
    return d;
  endfunction

  initial begin
    mode_e m;
    sb = new();
    in_valid = 0;
    in_beat = '0;
    rst_n = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_beat(MODE_DEC32, 64'h0000_0000_0012_3456);
    send_beat(MODE_DEC32, 64'hffff_ffff_01ff_ffff);
    send_beat(MODE_DEC32, 64'h0000_0000_0280_0002);
    send_beat(MODE_DEC32, 64'h0000_0000_0200_0006);
    send_beat(MODE_DEC32, 64'h0000_0000_ff7f_ffff);
    send_beat(MODE_ENC32, 64'h0000_0000_8000_0000);
    send_beat(MODE_ENC32, 64'h0000_0000_7f80_0000);
    send_beat(MODE_ENC32, 64'h0000_0000_7fc0_0001);
    send_beat(MODE_ENC32, 64'h0000_0000_7f00_0000);
    send_beat(MODE_ENC32, 64'h0000_0000_7e80_0000);
    send_beat(MODE_ENC32, 64'h0000_0000_001f_ffff);
    send_beat(MODE_ENC32, 64'h0000_0000_8040_0001);
    send_beat(MODE_ENC32, 64'hffff_ffff_0020_0000);
    send_beat(MODE_DEC64, 64'h00ff_ffff_ffff_ffff);
    send_beat(MODE_DEC64, 64'h81ff_ffff_ffff_fffc);
    send_beat(MODE_DEC64, 64'h017f_ffff_ffff_fffc);
    send_beat(MODE_DEC64, 64'hff80_0000_0000_0004);
    send_beat(MODE_ENC64, 64'h8000_0000_0000_0000);
    send_beat(MODE_ENC64, 64'h7ff0_0000_0000_0000);
    send_beat(MODE_ENC64, 64'h0000_0000_0000_0001);
    send_beat(MODE_ENC64, 64'h37e0_0000_0000_0000);
    send_beat(MODE_ENC64, 64'h37f0_0000_0000_0000);
    send_beat(MODE_ENC64, 64'h47ef_ffff_ffff_ffff);
    send_beat(MODE_ENC64, 64'h47f0_0000_0000_0000);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    for (int i = 0; i < 1150; i++) begin
      m = mode_e'($urandom_range(0, 3));
      send_beat(m, $urandom_range(0, 4) == 0 ? rand64() : shaped_data());
    end
    in_valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      out_stall <= 1'b0;
      @(posedge clk);
      if (out_valid && $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  initial begin
    wait (sending_done);
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end
endmodule
